>>> src/tccb_pkg.sv
// tccb_pkg: shared types, codes and constants of the text console cell buffer
// used by tccb_cell_mem, tccb_put_unit and text_console_cell_buffer_top
// no dependencies
package tccb_pkg;

    // default geometry of the cell store
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // item function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // special character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd3;

    // register reset values
    localparam logic [2:0] RST_FG_COLOR = 3'd7;
    localparam logic [2:0] RST_BG_COLOR = 3'd0;
    localparam logic [7:0] RST_COLUMNS  = 8'd80;
    localparam logic [6:0] RST_ROWS     = 7'd25;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [5:0] read_row;
    } req_t;

    typedef struct packed {
        logic       cell_written;
        logic [6:0] cell_col;
        logic [5:0] cell_row;
        logic [7:0] cell_char;
        logic       did_scroll;
        logic [6:0] cursor_col;
        logic [5:0] cursor_row;
        logic [7:0] read_char;
        logic [2:0] read_fg;
        logic [2:0] read_bg;
    } res_t;

    // one character cell: bg in 13..11, fg in 10..8, char in 7..0
    typedef struct packed {
        logic [2:0] bg;
        logic [2:0] fg;
        logic [7:0] ch;
    } cell_t;

    function automatic cell_t make_cell(logic [7:0] ch, logic [2:0] fg, logic [2:0] bg);
        cell_t c;
        c.ch = ch;
        c.fg = fg;
        c.bg = bg;
        return c;
    endfunction

endpackage

>>> src/tccb_cell_mem.sv
// tccb_cell_mem: synchronous cell store, one write port and one registered read port
// depends on tccb_pkg (cell_t)
module tccb_cell_mem #(
    parameter  int DEPTH = tccb_pkg::DEF_MAX_COLS * tccb_pkg::DEF_MAX_ROWS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tccb_pkg::cell_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output tccb_pkg::cell_t rd_data
);

    tccb_pkg::cell_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/tccb_put_unit.sv
// tccb_put_unit: cursor update and cell write for one put item
// depends on tccb_pkg (res_t, cell_t, character codes)
module tccb_put_unit #(
    parameter  int MAX_COLS = tccb_pkg::DEF_MAX_COLS,
    parameter  int MAX_ROWS = tccb_pkg::DEF_MAX_ROWS,
    localparam int XW  = $clog2(MAX_COLS + 1),
    localparam int YW  = $clog2(MAX_ROWS + 1),
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int AW  = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1
) (
    input  logic [XW-1:0]   cur_x,
    input  logic [YW-1:0]   cur_y,
    input  logic [7:0]      char_code,
    input  logic [XW-1:0]   nc,
    input  logic [YW-1:0]   nr,
    input  logic [2:0]      fg,
    input  logic [2:0]      bg,
    output tccb_pkg::res_t  res,
    output logic [XW-1:0]   new_x,
    output logic [YW-1:0]   new_y,
    output logic [AW-1:0]   wr_addr,
    output tccb_pkg::cell_t wr_cell
);

    logic [XW-1:0] sx;
    logic [YW-1:0] sy;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [XW-1:0] wcol;
    logic [YW-1:0] wrow;
    logic [7:0]    wch;
    logic          wr;
    logic          scroll;

    always_comb begin
        // pull the cursor back into a shrunk area
        sx = (cur_x >= nc) ? XW'(nc - XW'(1)) : cur_x;
        sy = (cur_y >= nr) ? YW'(nr - YW'(1)) : cur_y;
        nx   = sx;
        ny   = sy;
        wcol = sx;
        wrow = sy;
        wch  = char_code;
        wr   = 1'b0;
        case (char_code)
            tccb_pkg::CH_BACKSPACE: begin
                if (sx == '0) begin
                    if (sy != '0) begin
                        ny = YW'(sy - YW'(1));
                    end
                end else begin
                    nx = XW'(sx - XW'(1));
                end
                wcol = nx;
                wrow = ny;
                wch  = tccb_pkg::CH_SPACE;
                wr   = 1'b1;
            end
            tccb_pkg::CH_NEWLINE: begin
                nx = '0;
                ny = YW'(sy + YW'(1));
            end
            default: begin
                wr = 1'b1;
                nx = XW'(sx + XW'(1));
                if (nx >= nc) begin
                    nx = '0;
                    ny = YW'(sy + YW'(1));
                end
            end
        endcase
        scroll = (ny >= nr);
        if (scroll) begin
            ny = YW'(nr - YW'(1));
        end
    end

    assign new_x   = nx;
    assign new_y   = ny;
    assign wr_cell = tccb_pkg::make_cell(wch, fg, bg);
    assign wr_addr = AW'(32'(wrow[RIW-1:0]) * MAX_COLS + 32'(wcol[CIW-1:0]));

    always_comb begin
        res              = '0;
        res.cell_written = wr;
        res.cell_col     = wr ? 7'(wcol) : 7'd0;
        res.cell_row     = wr ? 6'(wrow) : 6'd0;
        res.cell_char    = wr ? wch : 8'd0;
        res.did_scroll   = scroll;
        res.cursor_col   = 7'(nx);
        res.cursor_row   = 6'(ny);
    end

endmodule

>>> src/text_console_cell_buffer_top.sv
// text_console_cell_buffer_top: text console cell store with cursor, put and read items
// depends on tccb_pkg, tccb_cell_mem, tccb_put_unit
// a read or a put without scroll goes from ST_IDLE to ST_EXEC, which registers its result
// or waits in ST_HOLD; a scrolling put runs ST_COPY, ST_DRAIN, ST_FILL (one row: ST_FILL only):
// one cell copy per cycle through the single-port-pair cell memory, then one fill write per cycle
// items are handled one at a time; s_ready is high only in ST_IDLE
// reset: cursor cleared and registers set to defaults at once; then a clearing pass writes
// MAX_COLS*MAX_ROWS cells (8192 at defaults) one per cycle, with no item taken meanwhile
module text_console_cell_buffer_top #(
    parameter int MAX_COLS = tccb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tccb_pkg::DEF_MAX_ROWS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [tccb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tccb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // item channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tccb_pkg::req_t                    s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output tccb_pkg::res_t                    m_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = $clog2(MAX_COLS + 1);
    localparam int YW    = $clog2(MAX_ROWS + 1);
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;  // post-reset clearing pass
    localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for an item
    localparam logic [2:0] ST_EXEC  = 3'd2;  // put write or read data return
    localparam logic [2:0] ST_COPY  = 3'd3;  // scroll: read row+1, write row
    localparam logic [2:0] ST_DRAIN = 3'd4;  // scroll: last pending copy write
    localparam logic [2:0] ST_FILL  = 3'd5;  // scroll: blank the bottom row
    localparam logic [2:0] ST_HOLD  = 3'd6;  // result waits for the output slot

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [XW-1:0]       cur_x_reg, cur_x_next;
    logic [YW-1:0]       cur_y_reg, cur_y_next;
    logic [XW-1:0]       sc_col_reg, sc_col_next;
    logic [YW-1:0]       sc_row_reg, sc_row_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    tccb_pkg::req_t      in_reg, in_next;
    logic                rd_ok_reg, rd_ok_next;
    tccb_pkg::res_t      res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    tccb_pkg::res_t      m_data_reg, m_data_next;

    // configuration registers
    logic [2:0]          fg_reg, fg_next;
    logic [2:0]          bg_reg, bg_next;
    logic [7:0]          cols_reg, cols_next;
    logic [6:0]          rows_reg, rows_next;

    // saturated area size
    logic [XW-1:0]       nc;
    logic [YW-1:0]       nr;

    // memory ports
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    tccb_pkg::cell_t     mem_wdata;
    logic [AW-1:0]       mem_raddr;
    tccb_pkg::cell_t     mem_rdata;

    // put unit results
    tccb_pkg::res_t      put_res;
    logic [XW-1:0]       put_x;
    logic [YW-1:0]       put_y;
    logic [AW-1:0]       put_addr;
    tccb_pkg::cell_t     put_cell;

    logic                s_xfer;
    logic                out_free;
    logic                in_range;
    logic [AW-1:0]       s_rd_addr;
    logic [AW-1:0]       copy_src;
    logic [AW-1:0]       copy_dst;
    logic [AW-1:0]       fill_addr;
    tccb_pkg::cell_t     fill_cell;
    tccb_pkg::res_t      read_res;

    // columns of 0 count as 1, above MAX_COLS as MAX_COLS; rows alike
    always_comb begin
        if (cols_reg == 8'd0) begin
            nc = XW'(1);
        end else if (9'(cols_reg) > 9'(MAX_COLS)) begin
            nc = XW'(MAX_COLS);
        end else begin
            nc = XW'(cols_reg);
        end
        if (rows_reg == 7'd0) begin
            nr = YW'(1);
        end else if (8'(rows_reg) > 8'(MAX_ROWS)) begin
            nr = YW'(MAX_ROWS);
        end else begin
            nr = YW'(rows_reg);
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // read address straight from the incoming item so data is back in ST_EXEC
    assign in_range  = (9'(s_data.read_col) < 9'(nc)) && (9'(s_data.read_row) < 9'(nr));
    assign s_rd_addr = AW'(32'(s_data.read_row) * MAX_COLS + 32'(s_data.read_col));

    // scroll addresses: source one row below the destination
    assign copy_src  = AW'((32'(sc_row_reg[RIW-1:0]) + 32'd1) * MAX_COLS
                           + 32'(sc_col_reg[CIW-1:0]));
    assign copy_dst  = AW'(32'(sc_row_reg[RIW-1:0]) * MAX_COLS + 32'(sc_col_reg[CIW-1:0]));
    assign fill_addr = AW'(32'(nr - YW'(1)) * MAX_COLS + 32'(sc_col_reg[CIW-1:0]));
    assign fill_cell = tccb_pkg::make_cell(tccb_pkg::CH_SPACE, fg_reg, bg_reg);

    tccb_put_unit #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_put (
        .cur_x     (cur_x_reg),
        .cur_y     (cur_y_reg),
        .char_code (in_reg.char_code),
        .nc        (nc),
        .nr        (nr),
        .fg        (fg_reg),
        .bg        (bg_reg),
        .res       (put_res),
        .new_x     (put_x),
        .new_y     (put_y),
        .wr_addr   (put_addr),
        .wr_cell   (put_cell)
    );

    tccb_cell_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // result of a read item: stored cursor, cell only if inside the area
    always_comb begin
        read_res            = '0;
        read_res.cursor_col = 7'(cur_x_reg);
        read_res.cursor_row = 6'(cur_y_reg);
        if (rd_ok_reg) begin
            read_res.read_char = mem_rdata.ch;
            read_res.read_fg   = mem_rdata.fg;
            read_res.read_bg   = mem_rdata.bg;
        end
    end

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_rdata;
        mem_raddr = (state_reg == ST_COPY) ? copy_src : s_rd_addr;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = tccb_pkg::make_cell(tccb_pkg::CH_SPACE, tccb_pkg::RST_FG_COLOR,
                                                tccb_pkg::RST_BG_COLOR);
            end
            ST_EXEC: begin
                mem_we    = (in_reg.func == tccb_pkg::FUNC_PUT) && put_res.cell_written;
                mem_waddr = put_addr;
                mem_wdata = put_cell;
            end
            ST_COPY, ST_DRAIN: begin
                // copy write follows its read in the next cycle
                mem_we    = pend_reg;
                mem_waddr = pend_addr_reg;
                mem_wdata = mem_rdata;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr;
                mem_wdata = fill_cell;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        sc_col_next    = sc_col_reg;
        sc_row_next    = sc_row_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        in_next        = in_reg;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;

        // drop the result once it has been taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = AW'(clr_addr_reg + AW'(1));
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    in_next    = s_data;
                    rd_ok_next = in_range;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (in_reg.func == tccb_pkg::FUNC_READ) begin
                    res_next = read_res;
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = read_res;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end else begin
                    cur_x_next = put_x;
                    cur_y_next = put_y;
                    res_next   = put_res;
                    if (put_res.did_scroll) begin
                        sc_col_next = '0;
                        sc_row_next = '0;
                        pend_next   = 1'b0;
                        // a single row has nothing to copy
                        state_next  = (nr == YW'(1)) ? ST_FILL : ST_COPY;
                    end else if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = put_res;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_COPY: begin
                pend_next      = 1'b1;
                pend_addr_next = copy_dst;
                if (sc_col_reg == XW'(nc - XW'(1))) begin
                    sc_col_next = '0;
                    if (YW'(sc_row_reg + YW'(1)) == YW'(nr - YW'(1))) begin
                        state_next = ST_DRAIN;
                    end else begin
                        sc_row_next = YW'(sc_row_reg + YW'(1));
                    end
                end else begin
                    sc_col_next = XW'(sc_col_reg + XW'(1));
                end
            end
            ST_DRAIN: begin
                pend_next   = 1'b0;
                sc_col_next = '0;
                state_next  = ST_FILL;
            end
            ST_FILL: begin
                if (sc_col_reg == XW'(nc - XW'(1))) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = res_reg;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end else begin
                    sc_col_next = XW'(sc_col_reg + XW'(1));
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes, taken in any state
    always_comb begin
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tccb_pkg::CFG_FG_COLOR: fg_next   = cfg_wdata[2:0];
                tccb_pkg::CFG_BG_COLOR: bg_next   = cfg_wdata[2:0];
                tccb_pkg::CFG_COLUMNS:  cols_next = cfg_wdata[7:0];
                tccb_pkg::CFG_ROWS:     rows_next = cfg_wdata[6:0];
                default: begin
                    fg_next = fg_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            fg_reg       <= tccb_pkg::RST_FG_COLOR;
            bg_reg       <= tccb_pkg::RST_BG_COLOR;
            cols_reg     <= tccb_pkg::RST_COLUMNS;
            rows_reg     <= tccb_pkg::RST_ROWS;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
        end
    end

    // payload and scroll counters
    always_ff @(posedge aclk) begin
        sc_col_reg    <= sc_col_next;
        sc_row_reg    <= sc_row_next;
        pend_addr_reg <= pend_addr_next;
        in_reg        <= in_next;
        rd_ok_reg     <= rd_ok_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

endmodule

>>> bench/text_console_cell_buffer_top_tb.sv
// text_console_cell_buffer_top_tb: self-checking bench for the text console cell buffer
// sends put and read items, writes the size and color registers, predicts each result
// depends on tccb_pkg and text_console_cell_buffer_top
`timescale 1ns / 100ps

module text_console_cell_buffer_top_tb;

    localparam int MAX_COLS      = tccb_pkg::DEF_MAX_COLS;
    localparam int MAX_ROWS      = tccb_pkg::DEF_MAX_ROWS;
    localparam int CELLS         = MAX_COLS * MAX_ROWS;
    localparam int IDLE_MAX      = 11;      // per-transfer idle draw, both sides
    localparam int LONG_HOLD     = 300;     // receiver hold-off that fills the block
    localparam int STALL_LIMIT   = 40000;   // covers the clearing pass and a full-size scroll
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX    = 10;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [tccb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tccb_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    tccb_pkg::req_t                  s_data;
    logic                            m_valid;
    logic                            m_ready;
    tccb_pkg::res_t                  m_data;

    text_console_cell_buffer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // shadow copy of the console: cell store, cursor and registers
    tccb_pkg::cell_t shadow_cells [CELLS];
    logic [6:0]      shadow_col;
    logic [5:0]      shadow_row;
    logic [2:0]      shadow_fg;
    logic [2:0]      shadow_bg;
    logic [7:0]      shadow_cols;
    logic [6:0]      shadow_rows;

    // results still owed by the block, oldest first
    tccb_pkg::res_t pending_results [$];

    int fault_count   = 0;
    int quiet_cycles  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int ready_stall   = 0;
    bit no_idle       = 1'b0;

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // size in use, with zero and oversize values saturated
    function automatic int span_cols();
        if (shadow_cols == 0) return 1;
        if (shadow_cols > MAX_COLS) return MAX_COLS;
        return int'(shadow_cols);
    endfunction

    function automatic int span_rows();
        if (shadow_rows == 0) return 1;
        if (shadow_rows > MAX_ROWS) return MAX_ROWS;
        return int'(shadow_rows);
    endfunction

    // applies one item to the shadow console and returns the result it owes
    function automatic tccb_pkg::res_t predict_console(tccb_pkg::req_t item);
        tccb_pkg::res_t  r;
        tccb_pkg::cell_t pen;
        int              nc, nr, x, y, rr, cc;
        r   = '0;
        nc  = span_cols();
        nr  = span_rows();
        pen = '{bg: shadow_bg, fg: shadow_fg, ch: tccb_pkg::CH_SPACE};
        if (item.func == tccb_pkg::FUNC_READ) begin
            // cells outside the size in use read as zero
            if (item.read_col < nc && item.read_row < nr) begin
                pen = shadow_cells[item.read_row * MAX_COLS + item.read_col];
                r.read_char = pen.ch;
                r.read_fg   = pen.fg;
                r.read_bg   = pen.bg;
            end
        end else begin
            // a cursor left outside a shrunk area is pulled back in first
            x = int'(shadow_col);
            y = int'(shadow_row);
            if (x >= nc) x = nc - 1;
            if (y >= nr) y = nr - 1;
            if (item.char_code == tccb_pkg::CH_BACKSPACE) begin
                if (x == 0) begin
                    if (y > 0) y = y - 1;
                end else begin
                    x = x - 1;
                end
                shadow_cells[y * MAX_COLS + x] = pen;
                r.cell_written = 1'b1;
                r.cell_col     = 7'(x);
                r.cell_row     = 6'(y);
                r.cell_char    = tccb_pkg::CH_SPACE;
            end else if (item.char_code == tccb_pkg::CH_NEWLINE) begin
                x = 0;
                y = y + 1;
            end else begin
                pen.ch = item.char_code;
                shadow_cells[y * MAX_COLS + x] = pen;
                r.cell_written = 1'b1;
                r.cell_col     = 7'(x);
                r.cell_row     = 6'(y);
                r.cell_char    = item.char_code;
                x = x + 1;
                if (x >= nc) begin
                    x = 0;
                    y = y + 1;
                end
            end
            // past the last row: shift the used area up, blank the bottom row
            if (y >= nr) begin
                for (rr = 0; rr + 1 < nr; rr++)
                    for (cc = 0; cc < nc; cc++)
                        shadow_cells[rr * MAX_COLS + cc] =
                            shadow_cells[(rr + 1) * MAX_COLS + cc];
                pen.ch = tccb_pkg::CH_SPACE;
                for (cc = 0; cc < nc; cc++)
                    shadow_cells[(nr - 1) * MAX_COLS + cc] = pen;
                y = nr - 1;
                r.did_scroll = 1'b1;
            end
            shadow_col = 7'(x);
            shadow_row = 6'(y);
        end
        r.cursor_col = shadow_col;
        r.cursor_row = shadow_row;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic string diff_fields(tccb_pkg::res_t want, tccb_pkg::res_t got);
        string s;
        s = "";
        if (got.cell_written !== want.cell_written) s = {s, " cell_written"};
        if (got.cell_col     !== want.cell_col)     s = {s, " cell_col"};
        if (got.cell_row     !== want.cell_row)     s = {s, " cell_row"};
        if (got.cell_char    !== want.cell_char)    s = {s, " cell_char"};
        if (got.did_scroll   !== want.did_scroll)   s = {s, " did_scroll"};
        if (got.cursor_col   !== want.cursor_col)   s = {s, " cursor_col"};
        if (got.cursor_row   !== want.cursor_row)   s = {s, " cursor_row"};
        if (got.read_char    !== want.read_char)    s = {s, " read_char"};
        if (got.read_fg      !== want.read_fg)      s = {s, " read_fg"};
        if (got.read_bg      !== want.read_bg)      s = {s, " read_bg"};
        return s;
    endfunction

    function automatic string show(tccb_pkg::res_t r);
        return $sformatf({"wr=%0d cell=(%0d,%0d) chr=%02h scroll=%0d ",
                          "cursor=(%0d,%0d) rd=%02h fg=%0d bg=%0d"},
                         r.cell_written, r.cell_col, r.cell_row, r.cell_char, r.did_scroll,
                         r.cursor_col, r.cursor_row, r.read_char, r.read_fg, r.read_bg);
    endfunction

    // every result transfer is matched against the oldest pending prediction
    always @(posedge aclk) begin : check_result
        tccb_pkg::res_t want;
        string          bad;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected result at %0t: %s", $realtime, show(m_data));
            end else begin
                want = pending_results.pop_front();
                bad  = diff_fields(want, m_data);
                if (bad != "") begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX) begin
                        $display("result mismatch at %0t in%s", $realtime, bad);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(m_data));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side flow control
    // ------------------------------------------------------------------

    // random stall after each transfer; a hold request drops ready while a countdown from LONG_HOLD runs
    always @(posedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            ready_stall  = LONG_HOLD;
        end else if (m_valid && m_ready) begin
            ready_stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        end else if (ready_stall != 0) begin
            ready_stall = ready_stall - 1;
        end
        m_ready <= (ready_stall == 0);
    end

    // watchdog: too long without any transfer or register write ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one item on the input channel; returns at the accepting edge with valid still high,
    // so the next item can follow back to back
    task automatic send_item(input tccb_pkg::req_t item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_console(item));
    endtask

    // sender goes quiet until every owed result has come back
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input logic [tccb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tccb_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            tccb_pkg::CFG_FG_COLOR: shadow_fg   = data[2:0];
            tccb_pkg::CFG_BG_COLOR: shadow_bg   = data[2:0];
            tccb_pkg::CFG_COLUMNS:  shadow_cols = data;
            tccb_pkg::CFG_ROWS:     shadow_rows = data[6:0];
            default: ;
        endcase
    endtask

    // registers change only with the block idle
    task automatic program_regs(input logic [7:0] fg, input logic [7:0] bg,
                                input logic [7:0] cols, input logic [7:0] rows);
        pause_until_drained();
        write_reg(tccb_pkg::CFG_FG_COLOR, fg);
        write_reg(tccb_pkg::CFG_BG_COLOR, bg);
        write_reg(tccb_pkg::CFG_COLUMNS, cols);
        write_reg(tccb_pkg::CFG_ROWS, rows);
        cfg_wr_en <= 1'b0;
    endtask

    // unused fields carry random bits so every input bit toggles
    function automatic tccb_pkg::req_t put_req(input logic [7:0] ch);
        tccb_pkg::req_t item;
        item.func      = tccb_pkg::FUNC_PUT;
        item.char_code = ch;
        item.read_col  = 7'($urandom_range(0, 127));
        item.read_row  = 6'($urandom_range(0, 63));
        return item;
    endfunction

    function automatic tccb_pkg::req_t read_req(input int col, input int row);
        tccb_pkg::req_t item;
        item.func      = tccb_pkg::FUNC_READ;
        item.char_code = 8'($urandom_range(0, 255));
        item.read_col  = 7'(col);
        item.read_row  = 6'(row);
        return item;
    endfunction

    // random mix: reads mostly inside the area, puts biased to backspace and newline
    function automatic tccb_pkg::req_t random_item();
        tccb_pkg::req_t item;
        int             pick;
        item = put_req(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            item.func = tccb_pkg::FUNC_READ;
            if (pick < 24) begin
                item.read_col = 7'($urandom_range(0, span_cols() - 1));
                item.read_row = 6'($urandom_range(0, span_rows() - 1));
            end
        end else if (pick < 42) begin
            item.char_code = tccb_pkg::CH_BACKSPACE;
        end else if (pick < 54) begin
            item.char_code = tccb_pkg::CH_NEWLINE;
        end
        return item;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // cleared store and register defaults, 80 x 25 white on black
    task automatic test_reset_state();
        send_item(read_req(0, 0));
        send_item(read_req(79, 24));
        send_item(read_req(80, 0));
        send_item(read_req(0, 25));
        send_item(read_req(127, 63));
        send_item(put_req("H"));
        send_item(read_req(0, 0));
    endtask

    // wrap, backspace at row start and at the origin, newline, scroll by newline and by wrap
    task automatic test_directed_edits();
        program_regs(8'd2, 8'd5, 8'd4, 8'd3);
        send_item(put_req(8'hFF));
        send_item(put_req(8'h00));
        send_item(put_req("A"));                      // wraps to the next row
        send_item(put_req(tccb_pkg::CH_BACKSPACE));   // column 0: up one row, stays at column 0
        send_item(put_req(tccb_pkg::CH_BACKSPACE));   // origin: cursor stays put
        send_item(put_req("B"));
        send_item(put_req(tccb_pkg::CH_BACKSPACE));   // plain step left
        send_item(put_req(tccb_pkg::CH_NEWLINE));
        send_item(put_req(tccb_pkg::CH_NEWLINE));
        send_item(put_req(tccb_pkg::CH_NEWLINE));     // off the bottom: scroll
        send_item(put_req("w"));
        send_item(put_req("x"));
        send_item(put_req("y"));
        send_item(put_req("z"));                      // wrap on the last row: write then scroll
        send_item(read_req(3, 1));
        send_item(read_req(0, 2));
        send_item(read_req(4, 0));
        send_item(read_req(0, 3));
    endtask

    // zero sizes count as one; cursor saturates into the shrunk area
    task automatic test_size_extremes();
        program_regs(8'hF8, 8'h07, 8'd0, 8'd0);
        send_item(put_req("Q"));            // cursor pulled in, every put but backspace scrolls
        send_item(read_req(0, 0));
        send_item(read_req(1, 0));
        send_item(put_req(tccb_pkg::CH_BACKSPACE));
        send_item(put_req(tccb_pkg::CH_NEWLINE));
        program_regs(8'h05, 8'hFA, 8'd1, 8'd64);
        repeat (6) send_item(put_req(8'($urandom_range(0, 255))));
        send_item(read_req(0, 5));
        send_item(read_req(0, 63));
    endtask

    // oversize values saturate to the full store; full-area scrolls by newline
    task automatic test_full_size();
        program_regs(8'h03, 8'h04, 8'hFF, 8'hFF);
        repeat (130) send_item(put_req(8'($urandom_range(0, 255))));
        repeat (64) send_item(put_req(tccb_pkg::CH_NEWLINE));
        send_item(read_req(127, 63));
        send_item(read_req(127, 0));
        send_item(read_req(0, 0));
        send_item(read_req($urandom_range(0, 127), $urandom_range(0, 63)));
        program_regs(8'h06, 8'h01, 8'd128, 8'd64);
        send_item(put_req("e"));
        send_item(put_req(tccb_pkg::CH_BACKSPACE));
        send_item(read_req(127, 63));
        send_item(read_req(0, 63));
    endtask

    // receiver holds off while the sender keeps offering back to back,
    // then the sender waits for every result
    task automatic test_output_stall();
        program_regs(8'd1, 8'd6, 8'd5, 8'd4);
        no_idle = 1'b1;
        hold_requests++;
        repeat (40) send_item(random_item());
        no_idle = 1'b0;
        pause_until_drained();
    endtask

    // sessions of random items, each with its own colors and mostly small sizes
    task automatic test_random_sessions();
        int session;
        int cols;
        int rows;
        for (session = 0; session < 14; session++) begin
            if (session % 5 == 4) begin
                cols = $urandom_range(13, 40);
                rows = $urandom_range(9, 20);
            end else begin
                cols = $urandom_range(0, 12);
                rows = $urandom_range(0, 8);
            end
            program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'(cols), 8'(rows));
            no_idle = (session % 4 == 3);
            repeat (100) send_item(random_item());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : main
        int i;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= tccb_pkg::CFG_FG_COLOR;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;

        // shadow state after reset
        for (i = 0; i < CELLS; i++)
            shadow_cells[i] = '{bg: tccb_pkg::RST_BG_COLOR, fg: tccb_pkg::RST_FG_COLOR,
                                ch: tccb_pkg::CH_SPACE};
        shadow_col  = '0;
        shadow_row  = '0;
        shadow_fg   = tccb_pkg::RST_FG_COLOR;
        shadow_bg   = tccb_pkg::RST_BG_COLOR;
        shadow_cols = tccb_pkg::RST_COLUMNS;
        shadow_rows = tccb_pkg::RST_ROWS;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // the block clears its store before it takes the first transfer
        do @(posedge aclk); while (s_ready !== 1'b1);

        test_reset_state();
        test_directed_edits();
        test_size_extremes();
        test_full_size();
        test_output_stall();
        test_random_sessions();

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
